FILE: hdl/range_max_min_spread_query_core_macros.svh
// Assertion macros shared by the range spread query core.
`ifndef RANGE_MAX_MIN_SPREAD_QUERY_CORE_MACROS_SVH
`define RANGE_MAX_MIN_SPREAD_QUERY_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RMMSQ_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RMMSQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/rmmsq_pkg.sv
// Shared constants, types and the microcode table of the range spread query core.
package rmmsq_pkg;

    localparam int MAX_ELEMENTS = 65536;
    localparam int BLOCK_SIZE   = 32;
    localparam int POS_W        = $clog2(MAX_ELEMENTS);
    localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);
    localparam int OFF_W        = $clog2(BLOCK_SIZE);
    localparam int BLK_W        = POS_W - OFF_W;
    localparam int NUM_BLOCKS   = (MAX_ELEMENTS + BLOCK_SIZE - 1) / BLOCK_SIZE;
    localparam int DATA_W       = 32;
    localparam int KIND_W       = 2;
    localparam int LR_W         = 17;
    localparam int CMP_W        = (CNT_W > LR_W) ? CNT_W : LR_W;
    localparam int STEP_W       = 4;

    localparam logic [CNT_W-1:0]  MAX_COUNT = CNT_W'(MAX_ELEMENTS);
    localparam logic [DATA_W-1:0] SIGN_FLIP = {1'b1, {(DATA_W-1){1'b0}}};

    localparam logic [KIND_W-1:0] KIND_APPEND  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_QUERY   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RESTART = 2'd2;

    // Microcode addresses.
    localparam logic [STEP_W-1:0] S_IDLE     = 4'd0;
    localparam logic [STEP_W-1:0] S_DISPATCH = 4'd1;
    localparam logic [STEP_W-1:0] S_UPDATE   = 4'd2;
    localparam logic [STEP_W-1:0] S_CHECK    = 4'd3;
    localparam logic [STEP_W-1:0] S_SCAN_A   = 4'd4;
    localparam logic [STEP_W-1:0] S_SETUP_B  = 4'd5;
    localparam logic [STEP_W-1:0] S_SKIP_B   = 4'd6;
    localparam logic [STEP_W-1:0] S_SCAN_B   = 4'd7;
    localparam logic [STEP_W-1:0] S_SETUP_C  = 4'd8;
    localparam logic [STEP_W-1:0] S_SCAN_C   = 4'd9;
    localparam logic [STEP_W-1:0] S_DRAIN    = 4'd10;
    localparam logic [STEP_W-1:0] S_EMIT     = 4'd11;
    localparam logic [STEP_W-1:0] S_ERROR    = 4'd12;

    typedef enum logic [3:0] {
        OP_NONE     = 4'd0,
        OP_UPDATE   = 4'd1,
        OP_INIT     = 4'd2,
        OP_RD_ELEM  = 4'd3,
        OP_LOAD_B   = 4'd4,
        OP_RD_BLOCK = 4'd5,
        OP_LOAD_C   = 4'd6,
        OP_EMIT     = 4'd7,
        OP_EMIT_ERR = 4'd8
    } t_op;

    typedef enum logic [2:0] {
        C_NEVER      = 3'd0,
        C_ALWAYS     = 3'd1,
        C_NOT_START  = 3'd2,
        C_IS_QUERY   = 3'd3,
        C_RANGE_ERR  = 3'd4,
        C_PTR_NE_END = 3'd5,
        C_SAME_BLOCK = 3'd6,
        C_ADJACENT   = 3'd7
    } t_cond;

    // One control word: a datapath operation and a conditional jump.
    // When the condition fails the step counter advances by one.
    typedef struct packed {
        t_op               op;
        t_cond             cond;
        logic [STEP_W-1:0] target;
    } t_ctrl;

    typedef struct packed {
        logic is_query;
        logic range_err;
        logic ptr_ne_end;
        logic same_block;
        logic adjacent;
    } t_status;

    function automatic t_ctrl ucode(input logic [STEP_W-1:0] step);
        t_ctrl w;
        w = '{op: OP_NONE, cond: C_ALWAYS, target: S_IDLE};
        case (step)
            S_IDLE:     w = '{op: OP_NONE,     cond: C_NOT_START,  target: S_IDLE};
            S_DISPATCH: w = '{op: OP_NONE,     cond: C_IS_QUERY,   target: S_CHECK};
            S_UPDATE:   w = '{op: OP_UPDATE,   cond: C_ALWAYS,     target: S_IDLE};
            S_CHECK:    w = '{op: OP_INIT,     cond: C_RANGE_ERR,  target: S_ERROR};
            S_SCAN_A:   w = '{op: OP_RD_ELEM,  cond: C_PTR_NE_END, target: S_SCAN_A};
            S_SETUP_B:  w = '{op: OP_LOAD_B,   cond: C_SAME_BLOCK, target: S_DRAIN};
            S_SKIP_B:   w = '{op: OP_NONE,     cond: C_ADJACENT,   target: S_SETUP_C};
            S_SCAN_B:   w = '{op: OP_RD_BLOCK, cond: C_PTR_NE_END, target: S_SCAN_B};
            S_SETUP_C:  w = '{op: OP_LOAD_C,   cond: C_NEVER,      target: S_IDLE};
            S_SCAN_C:   w = '{op: OP_RD_ELEM,  cond: C_PTR_NE_END, target: S_SCAN_C};
            S_DRAIN:    w = '{op: OP_NONE,     cond: C_NEVER,      target: S_IDLE};
            S_EMIT:     w = '{op: OP_EMIT,     cond: C_ALWAYS,     target: S_IDLE};
            S_ERROR:    w = '{op: OP_EMIT_ERR, cond: C_ALWAYS,     target: S_IDLE};
            default:    w = '{op: OP_NONE,     cond: C_ALWAYS,     target: S_IDLE};
        endcase
        return w;
    endfunction

endpackage

FILE: hdl/range_max_min_spread_query_core.sv
// Top level of the range spread query core.
//
// Command channel: a transaction is taken at a rising edge where start is high
// and busy is low. Kind 0 appends i_value at the next position, kind 2 empties
// the set, kind 1 asks for max minus min over the 1-based inclusive range
// [i_left, i_right]; kind 3 is ignored.
// Result channel: each query gives one result, shown on o_spread and
// o_range_error for exactly one cycle while o_strobe is high. The receiver
// cannot stall, so results are never held. Appends and restarts give none.
// An append, restart or ignored kind keeps busy high through the dispatch
// and update steps, a bad range through dispatch, check and error, and
// o_strobe rises in the cycle where busy falls. A valid query scans the
// elements of the first partial end block, the whole blocks in between and
// the elements of the last partial end block (only the first when the range
// lies inside one block), up to 32 elements per partial block and up to 2046
// whole blocks; the scans issue one memory read per cycle and set the time.
// Reset clears the element count and the sequencer; the stores need no
// clearing because only positions below the count are ever read.
module range_max_min_spread_query_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [rmmsq_pkg::KIND_W-1:0]        i_kind,
    input  logic signed [rmmsq_pkg::DATA_W-1:0] i_value,
    input  logic [rmmsq_pkg::LR_W-1:0]          i_left,
    input  logic [rmmsq_pkg::LR_W-1:0]          i_right,
    output logic                                o_strobe,
    output logic [rmmsq_pkg::DATA_W-1:0]        o_spread,
    output logic                                o_range_error
);

    rmmsq_pkg::t_ctrl   ctrl;
    rmmsq_pkg::t_status status;
    logic               accept;

    assign accept = start && !busy;

    rmmsq_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (status),
        .o_ctrl   (ctrl),
        .o_busy   (busy)
    );

    rmmsq_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_kind        (i_kind),
        .i_value       (i_value),
        .i_left        (i_left),
        .i_right       (i_right),
        .i_ctrl        (ctrl),
        .o_status      (status),
        .o_strobe      (o_strobe),
        .o_spread      (o_spread),
        .o_range_error (o_range_error)
    );

endmodule

FILE: hdl/rmmsq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rmmsq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/rmmsq_dp.sv
// Datapath of the range spread query core: stores, pointers and extrema accumulators.
`include "range_max_min_spread_query_core_macros.svh"

module rmmsq_dp (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_accept,
    input  logic [rmmsq_pkg::KIND_W-1:0]          i_kind,
    input  logic signed [rmmsq_pkg::DATA_W-1:0]   i_value,
    input  logic [rmmsq_pkg::LR_W-1:0]            i_left,
    input  logic [rmmsq_pkg::LR_W-1:0]            i_right,
    input  rmmsq_pkg::t_ctrl                      i_ctrl,
    output rmmsq_pkg::t_status                    o_status,
    output logic                                  o_strobe,
    output logic [rmmsq_pkg::DATA_W-1:0]          o_spread,
    output logic                                  o_range_error
);

    localparam int POS_W  = rmmsq_pkg::POS_W;
    localparam int OFF_W  = rmmsq_pkg::OFF_W;
    localparam int BLK_W  = rmmsq_pkg::BLK_W;
    localparam int CNT_W  = rmmsq_pkg::CNT_W;
    localparam int DATA_W = rmmsq_pkg::DATA_W;
    localparam int LR_W   = rmmsq_pkg::LR_W;
    localparam int CMP_W  = rmmsq_pkg::CMP_W;

    // Latched transaction fields.
    logic [rmmsq_pkg::KIND_W-1:0] r_kind;
    logic [DATA_W-1:0]            r_value;
    logic [LR_W-1:0]              r_left;
    logic [LR_W-1:0]              r_right;

    logic [CNT_W-1:0]  r_count;
    logic [DATA_W-1:0] r_cur_max, r_cur_min;
    logic [POS_W-1:0]  r_ptr, r_end;
    logic [DATA_W-1:0] r_hi, r_lo;
    logic              r_rd_vld, r_rd_blk;
    logic              r_strobe, r_err;
    logic [DATA_W-1:0] r_spread;

    logic [DATA_W-1:0] key, n_cur_max, n_cur_min;
    logic              full, blk_start, append_we;
    logic [POS_W-1:0]  lo_pos, hi_pos, end_a;
    logic [BLK_W-1:0]  bl, br;
    logic              range_err;
    logic [DATA_W-1:0] elem_q, bmax_q, bmin_q, cand_hi, cand_lo;

    // Keys carry an inverted sign bit so that unsigned order is signed order.
    assign key       = r_value ^ rmmsq_pkg::SIGN_FLIP;
    assign full      = (r_count == rmmsq_pkg::MAX_COUNT);
    assign blk_start = (r_count[OFF_W-1:0] == '0);
    assign n_cur_max = (blk_start || key > r_cur_max) ? key : r_cur_max;
    assign n_cur_min = (blk_start || key < r_cur_min) ? key : r_cur_min;
    assign append_we = (i_ctrl.op == rmmsq_pkg::OP_UPDATE)
                       && (r_kind == rmmsq_pkg::KIND_APPEND) && !full;

    assign range_err = (r_left == '0) || (r_left > r_right)
                       || (CMP_W'(r_right) > CMP_W'(r_count));
    assign lo_pos    = POS_W'(r_left - LR_W'(1));
    assign hi_pos    = POS_W'(r_right - LR_W'(1));
    assign bl        = lo_pos[POS_W-1:OFF_W];
    assign br        = hi_pos[POS_W-1:OFF_W];
    assign end_a     = (bl == br) ? hi_pos : {bl, {OFF_W{1'b1}}};

    assign o_status.is_query   = (r_kind == rmmsq_pkg::KIND_QUERY);
    assign o_status.range_err  = range_err;
    assign o_status.ptr_ne_end = (r_ptr != r_end);
    assign o_status.same_block = (bl == br);
    assign o_status.adjacent   = (br == bl + BLK_W'(1));

    rmmsq_ram #(.WIDTH(DATA_W), .DEPTH(rmmsq_pkg::MAX_ELEMENTS)) u_elem (
        .i_clk   (i_clk),
        .i_we    (append_we),
        .i_waddr (r_count[POS_W-1:0]),
        .i_wdata (key),
        .i_raddr (r_ptr),
        .o_rdata (elem_q)
    );

    rmmsq_ram #(.WIDTH(DATA_W), .DEPTH(rmmsq_pkg::NUM_BLOCKS)) u_bmax (
        .i_clk   (i_clk),
        .i_we    (append_we),
        .i_waddr (r_count[POS_W-1:OFF_W]),
        .i_wdata (n_cur_max),
        .i_raddr (r_ptr[BLK_W-1:0]),
        .o_rdata (bmax_q)
    );

    rmmsq_ram #(.WIDTH(DATA_W), .DEPTH(rmmsq_pkg::NUM_BLOCKS)) u_bmin (
        .i_clk   (i_clk),
        .i_we    (append_we),
        .i_waddr (r_count[POS_W-1:OFF_W]),
        .i_wdata (n_cur_min),
        .i_raddr (r_ptr[BLK_W-1:0]),
        .o_rdata (bmin_q)
    );

    assign cand_hi = r_rd_blk ? bmax_q : elem_q;
    assign cand_lo = r_rd_blk ? bmin_q : elem_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_rd_vld <= 1'b0;
            r_rd_blk <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_rd_vld <= (i_ctrl.op == rmmsq_pkg::OP_RD_ELEM)
                        || (i_ctrl.op == rmmsq_pkg::OP_RD_BLOCK);
            r_rd_blk <= (i_ctrl.op == rmmsq_pkg::OP_RD_BLOCK);
            r_strobe <= (i_ctrl.op == rmmsq_pkg::OP_EMIT)
                        || (i_ctrl.op == rmmsq_pkg::OP_EMIT_ERR);
            if (i_ctrl.op == rmmsq_pkg::OP_UPDATE) begin
                case (r_kind)
                    rmmsq_pkg::KIND_APPEND: begin
                        if (!full) begin
                            r_count <= r_count + CNT_W'(1);
                        end
                    end
                    rmmsq_pkg::KIND_RESTART: begin
                        r_count <= '0;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_kind  <= i_kind;
            r_value <= i_value;
            r_left  <= i_left;
            r_right <= i_right;
        end
        if (append_we) begin
            r_cur_max <= n_cur_max;
            r_cur_min <= n_cur_min;
        end
        // Read data arrives in the cycle after its address, so folding trails the scan.
        if (r_rd_vld) begin
            if (cand_hi > r_hi) begin
                r_hi <= cand_hi;
            end
            if (cand_lo < r_lo) begin
                r_lo <= cand_lo;
            end
        end
        case (i_ctrl.op)
            rmmsq_pkg::OP_INIT: begin
                r_hi  <= '0;
                r_lo  <= '1;
                r_ptr <= lo_pos;
                r_end <= end_a;
            end
            rmmsq_pkg::OP_RD_ELEM, rmmsq_pkg::OP_RD_BLOCK: begin
                r_ptr <= r_ptr + POS_W'(1);
            end
            rmmsq_pkg::OP_LOAD_B: begin
                r_ptr <= POS_W'(bl + BLK_W'(1));
                r_end <= POS_W'(br - BLK_W'(1));
            end
            rmmsq_pkg::OP_LOAD_C: begin
                r_ptr <= {br, {OFF_W{1'b0}}};
                r_end <= hi_pos;
            end
            rmmsq_pkg::OP_EMIT: begin
                r_spread <= r_hi - r_lo;
                r_err    <= 1'b0;
            end
            rmmsq_pkg::OP_EMIT_ERR: begin
                r_spread <= '0;
                r_err    <= 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign o_strobe      = r_strobe;
    assign o_spread      = r_spread;
    assign o_range_error = r_err;

    `RMMSQ_ASSERT_SAME(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= rmmsq_pkg::MAX_COUNT, "element count exceeds capacity")
    `RMMSQ_ASSERT_SAME(a_err_zero, i_clk, i_rst_n, r_strobe && r_err, r_spread == '0, "error result carries a nonzero spread")
    `RMMSQ_ASSERT_SAME(a_fold_order, i_clk, i_rst_n, r_strobe && !r_err, r_hi >= r_lo, "valid query folded no element")

endmodule

FILE: hdl/rmmsq_seq.sv
// Microcode sequencer: step counter, control word lookup and conditional jumps.
`include "range_max_min_spread_query_core_macros.svh"

module rmmsq_seq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  rmmsq_pkg::t_status i_status,
    output rmmsq_pkg::t_ctrl   o_ctrl,
    output logic               o_busy
);

    logic [rmmsq_pkg::STEP_W-1:0] r_step, n_step;
    rmmsq_pkg::t_ctrl             ctrl;
    logic                         take;

    assign ctrl = rmmsq_pkg::ucode(r_step);

    always_comb begin
        case (ctrl.cond)
            rmmsq_pkg::C_NEVER:      take = 1'b0;
            rmmsq_pkg::C_ALWAYS:     take = 1'b1;
            rmmsq_pkg::C_NOT_START:  take = !i_start;
            rmmsq_pkg::C_IS_QUERY:   take = i_status.is_query;
            rmmsq_pkg::C_RANGE_ERR:  take = i_status.range_err;
            rmmsq_pkg::C_PTR_NE_END: take = i_status.ptr_ne_end;
            rmmsq_pkg::C_SAME_BLOCK: take = i_status.same_block;
            rmmsq_pkg::C_ADJACENT:   take = i_status.adjacent;
            default:                 take = 1'b1;
        endcase
        n_step = take ? ctrl.target : r_step + rmmsq_pkg::STEP_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= rmmsq_pkg::S_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    assign o_ctrl = ctrl;
    assign o_busy = (r_step != rmmsq_pkg::S_IDLE);

    `RMMSQ_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, i_start && !o_busy, o_busy, "accepted transaction did not start work")
    `RMMSQ_ASSERT_SAME(a_step_range, i_clk, i_rst_n, 1'b1, r_step <= rmmsq_pkg::S_ERROR, "step counter left the program")

endmodule
